/* rtl/core/bct_pkg.sv */
package bct_pkg;

    // Table geometry: rows 0 .. ROWS-1 are held, row by row.
    localparam int ROWS        = 64;
    localparam int TABLE_DEPTH = ROWS * (ROWS + 1) / 2;
    localparam int IDX_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths of the query and result words.
    localparam int ROW_W   = 7;
    localparam int COL_W   = 7;
    localparam int COEFF_W = 64;
    localparam int STAT_W  = 2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_COL_OVER = 2'd1;
    localparam logic [STAT_W-1:0] ST_ROW_OVER = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // take the query word
        logic rd_fill;     // read the entry above the next fill entry
        logic rd_query;    // read the queried entry
        logic write_edge;  // write 1 at the next fill entry
        logic write_sum;   // write the sum of the two entries above
        logic load_out;    // load the result register
    } bct_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic query_ok;    // the captured query is inside the table
        logic need_fill;   // the queried entry is not filled yet
        logic fill_edge;   // the next fill entry is on the triangle's edge
    } bct_stat_t;

endpackage

/* rtl/core/bct_if.sv */
// Query channel: one word carries a row and a column.
interface bct_query_if;
    import bct_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;

    modport source (output valid, output row, output column, input ready);
    modport sink (input valid, input row, input column, output ready);
endinterface

// Result channel: one word carries a coefficient and a status.
interface bct_result_if;
    import bct_pkg::*;

    logic               valid;
    logic               ready;
    logic [COEFF_W-1:0] coefficient;
    logic [STAT_W-1:0]  status;

    modport source (output valid, output coefficient, output status, input ready);
    modport sink (input valid, input coefficient, input status, output ready);
endinterface

/* rtl/core/bct_ctrl.sv */
module bct_ctrl
    import bct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  bct_stat_t stat,
    output bct_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FILL,
        S_ADD,
        S_READ,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!stat.query_ok)
                begin
                    state_next = S_DONE;
                end
                else if (stat.need_fill)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_FILL:
            begin
                if (stat.fill_edge)
                begin
                    cmd.write_edge = 1'b1;
                    state_next     = S_CHECK;
                end
                else
                begin
                    cmd.rd_fill = 1'b1;
                    state_next  = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.write_sum = 1'b1;
                state_next    = S_CHECK;
            end
            S_READ:
            begin
                cmd.rd_query = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and the result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/core/bct_dp.sv */
module bct_dp
    import bct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ROW_W-1:0]   row,
    input  logic [COL_W-1:0]   column,
    input  bct_cmd_t           cmd,
    output bct_stat_t          stat,
    output logic [COEFF_W-1:0] coefficient,
    output logic [STAT_W-1:0]  status
);

    logic [COEFF_W-1:0] mem [TABLE_DEPTH];

    logic [IDX_W-1:0]   idx_reg;
    logic [STAT_W-1:0]  qstat_reg;
    logic [IDX_W-1:0]   filled_reg;
    logic [ROW_W-1:0]   fill_row_reg;
    logic [COL_W-1:0]   fill_col_reg;
    logic [COEFF_W-1:0] rd_data_reg;
    logic [COEFF_W-1:0] prev_reg;
    logic [COEFF_W-1:0] coeff_reg;
    logic [STAT_W-1:0]  status_reg;

    logic [2*ROW_W+1:0] row_prod;
    logic [IDX_W-1:0]   idx_next;
    logic [STAT_W-1:0]  qstat_next;
    logic [IDX_W-1:0]   up_addr;
    logic [IDX_W-1:0]   rd_addr;
    logic [COEFF_W-1:0] wr_data;
    logic               wr_en;
    logic               fill_last_col;

    // Index of (row, column) in the row-by-row triangle.
    assign row_prod = {{(ROW_W+2){1'b0}}, row} * ({{(ROW_W+2){1'b0}}, row} + 1'b1);
    assign idx_next = row_prod[IDX_W:1] + {{(IDX_W-COL_W){1'b0}}, column};

    // Query classification; the row check wins over the column check.
    always_comb
    begin
        if ({1'b0, row} >= (ROW_W+1)'(ROWS))
        begin
            qstat_next = ST_ROW_OVER;
        end
        else if (column > row)
        begin
            qstat_next = ST_COL_OVER;
        end
        else
        begin
            qstat_next = ST_OK;
        end
    end

    // The entry above the next fill entry sits one row length back.
    assign up_addr       = filled_reg - {{(IDX_W-ROW_W){1'b0}}, fill_row_reg};
    assign rd_addr       = cmd.rd_fill ? up_addr : idx_reg;
    assign fill_last_col = (fill_col_reg >= fill_row_reg);
    assign wr_en         = cmd.write_edge || cmd.write_sum;
    assign wr_data       = cmd.write_sum ? (prev_reg + rd_data_reg) : COEFF_W'(1);

    assign stat.query_ok  = (qstat_reg == ST_OK);
    assign stat.need_fill = (filled_reg <= idx_reg);
    assign stat.fill_edge = (fill_col_reg == '0) || fill_last_col;

    assign coefficient = coeff_reg;
    assign status      = status_reg;

    // Coefficient store with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[filled_reg] <= wr_data;
        end
        if (cmd.rd_fill || cmd.rd_query)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Fill position, advanced once per written entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg   <= '0;
            fill_row_reg <= '0;
            fill_col_reg <= '0;
        end
        else if (wr_en)
        begin
            filled_reg <= filled_reg + 1'b1;
            if (fill_last_col)
            begin
                fill_row_reg <= fill_row_reg + 1'b1;
                fill_col_reg <= '0;
            end
            else
            begin
                fill_col_reg <= fill_col_reg + 1'b1;
            end
        end
    end

    // Query, left neighbor of the upper pair, and the result word.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg   <= idx_next;
            qstat_reg <= qstat_next;
        end
        // Along a row the right upper entry becomes the next left one.
        if (cmd.write_edge)
        begin
            prev_reg <= COEFF_W'(1);
        end
        else if (cmd.write_sum)
        begin
            prev_reg <= rd_data_reg;
        end
        if (cmd.load_out)
        begin
            coeff_reg  <= (qstat_reg == ST_OK) ? rd_data_reg : '0;
            status_reg <= qstat_reg;
        end
    end

endmodule

/* rtl/core/binomial_coefficient_table.sv */
// Returns C(row, column) from a Pascal's triangle table that fills itself on
// demand. A query whose entry is already filled goes through capture, check,
// one read of the single coefficient memory and the load of the result word,
// which waits while the last result has not been taken. A query past the
// filled part first extends the fill in index order: an entry on the
// triangle's edge is written as 1 directly, and an interior entry takes a
// read and then a write of the sum, since each interior sum reads one entry
// above from the same memory port and reuses the other from the step before.
// A row at or beyond the table's 64 rows, or a column past its row, goes only
// through capture, check and load, returns 0 with an error status and fills
// nothing. The result register lets the next query enter while the last
// result waits to be taken.
module binomial_coefficient_table
    import bct_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    bct_query_if.sink    query,
    bct_result_if.source result
);

    bct_cmd_t  cmd;
    bct_stat_t stat;

    bct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (query.valid),
        .in_ready  (query.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bct_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .row         (query.row),
        .column      (query.column),
        .cmd         (cmd),
        .stat        (stat),
        .coefficient (result.coefficient),
        .status      (result.status)
    );

    // A query is worked one at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        query.valid && query.ready |=> !query.ready)
        else $error("query accepted while another is in work");

    // An error result carries a zero coefficient.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status != ST_OK |-> result.coefficient == '0)
        else $error("error result with nonzero coefficient");

    // Every binomial coefficient in the table is at least one.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == ST_OK |-> result.coefficient != '0)
        else $error("valid result with zero coefficient");

endmodule
